// ----- rtl/sobel_pkg.sv -----
// sobel_pkg: shared types and constants for the Sobel edge magnitude unit.
// Used by sobel_ctrl, sobel_dp and sobel_edge_magnitude_unit. No dependencies.
`default_nettype none

package sobel_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int THR_W      = 11;
    localparam int SUM_W      = 21;     // |gx|^2 + |gy|^2, both at most 1020
    localparam int THR_SQ_W   = 22;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESH  = 2'd3;

    localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT = 16'd1024;
    localparam logic [THR_W-1:0] RST_EDGE_THRESH  = 11'd40;

    localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

    // one window column: [0] top, [1] middle, [2] bottom
    typedef logic [2:0][PIX_W-1:0] t_col;

    typedef struct packed {
        logic accept;     // input transaction taken this cycle
        logic load_col;   // line store data valid: shift window, write stores
        logic grad;       // form |gx|, |gy|
        logic second;     // working on the right-edge result
        logic square;     // form the sum of squares, clear the root unit
        logic root_step;  // one digit of the square root
        logic push;       // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic ignore;     // offered item gives nothing and changes nothing
        logic want1;      // item gives the result one column behind
        logic want2;      // item gives the right-edge result
        logic fast;       // no root needed (threshold mode or saturated)
        logic root_last;  // last root digit being formed
        logic out_free;   // output register can take a result
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/sobel_ram.sv -----
// sobel_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/sobel_ctrl.sv -----
// sobel_ctrl: sequencing state machine for the Sobel edge magnitude unit.
// Depends on sobel_pkg (command and status structs).
`default_nettype none

module sobel_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire sobel_pkg::t_dp_status i_status,
    output sobel_pkg::t_dp_cmd         o_cmd
);
    import sobel_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GRAD,
        ST_SQR,
        ST_ROOT,
        ST_PUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_s_tready;

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        o_cmd    = '0;
        o_cmd.second = r_second;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_s_tvalid & r_s_tready;
                if (i_s_tvalid && r_s_tready && !i_status.ignore) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.load_col = 1'b1;
                if (i_status.want1 || i_status.want2) begin
                    n_second = ~i_status.want1;
                    n_state  = ST_GRAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state    = ST_SQR;
            end
            ST_SQR: begin
                o_cmd.square = 1'b1;
                n_state      = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.fast || i_status.root_last) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    if (!r_second && i_status.want2) begin
                        n_second = 1'b1;
                        n_state  = ST_GRAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_second   <= 1'b0;
            r_s_tready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_second   <= n_second;
            r_s_tready <= (n_state == ST_IDLE);
        end
    end

    assign o_s_tready = r_s_tready;

    // a result is never loaded over one still waiting
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_status.out_free)
        else $error("result pushed into a full output register");

    // the root phase ends no later than its last digit
    a_root_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT && i_status.root_last) |=> (r_state == ST_PUSH))
        else $error("square root overran its digit count");

    // the right-edge result always follows the left one for the same item
    a_second_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.push && !r_second && i_status.want2) |=> (r_state == ST_GRAD && r_second))
        else $error("second result of an item was skipped");

    // no new item is taken while the line stores are read for the last one
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !o_s_tready)
        else $error("input ready while an item is in flight");

endmodule

`default_nettype wire

// ----- rtl/sobel_dp.sv -----
// sobel_dp: datapath of the Sobel edge magnitude unit: counters, line stores,
// window, gradient, square-root unit and output register.
// Depends on sobel_pkg and sobel_ram.
`default_nettype none

module sobel_dp #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire sobel_pkg::t_dp_cmd                   i_cmd,
    output sobel_pkg::t_dp_status                     o_status,
    input  wire logic                                 i_cfg_we,
    input  wire logic [sobel_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [sobel_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic [sobel_pkg::PIX_W-1:0]          i_s_tdata,
    input  wire logic                                 i_s_tuser,
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic      [sobel_pkg::PIX_W-1:0]          o_m_tdata,
    output logic                                      o_m_tlast,
    output logic                                      o_m_tuser
);
    import sobel_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
    localparam logic [WW-1:0] W_ONE = WW'(1);

    // configuration
    logic [FW_W-1:0]     r_frame_width;
    logic [FH_W-1:0]     r_frame_height;
    logic                r_thr_mode;
    logic [THR_W-1:0]    r_edge_thr;
    logic [THR_SQ_W-1:0] r_thr_sq;

    // position
    logic [XW-1:0]   r_col_cnt, r_drain_cnt;
    logic [FH_W-1:0] r_row_cnt;

    // latched item
    logic            r_drain;
    logic [PIX_W-1:0] r_pix;
    logic [XW-1:0]   r_x;
    logic            r_want1, r_want2, r_top_is_bot;

    t_col r_win [3];

    logic [9:0]       r_abs_x, r_abs_y;
    logic [SUM_W-1:0] r_sum;
    logic [8:0]       r_rem;
    logic [7:0]       r_root;
    logic [2:0]       r_step;

    logic             r_out_valid, r_out_last, r_out_user;
    logic [PIX_W-1:0] r_out_data;

    // geometry
    logic [WW-1:0]   w_eff, w_last, cnt_ext, x_next;
    logic [FH_W-1:0] h_eff;
    logic [XW-1:0]   cnt_sel, x_now;
    logic            emit, wrap, cfg_geom;

    always_comb begin
        if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = W_MAX;
        end else if (r_frame_width == '0) begin
            w_eff = W_ONE;
        end else begin
            w_eff = WW'(r_frame_width);
        end
        w_last  = w_eff - W_ONE;
        h_eff   = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
        cnt_sel = i_s_tuser ? r_drain_cnt : r_col_cnt;
        cnt_ext = WW'(cnt_sel);
        x_now   = (cnt_ext >= w_eff) ? w_last[XW-1:0] : cnt_sel;
        x_next  = WW'(x_now) + W_ONE;
        wrap    = (x_next >= w_eff);
        emit    = i_s_tuser | (r_row_cnt != '0);
    end

    assign o_status.ignore = i_s_tuser ? (r_row_cnt < h_eff) : (r_row_cnt >= h_eff);
    assign cfg_geom = i_cfg_we &&
        (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_thr_mode     <= 1'b0;
            r_edge_thr     <= RST_EDGE_THRESH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[FH_W-1:0];
                CFG_THRESH_MODE:  r_thr_mode     <= i_cfg_wdata[0];
                CFG_EDGE_THRESH:  r_edge_thr     <= i_cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_sq <= THR_SQ_W'(r_edge_thr) * THR_SQ_W'(r_edge_thr);
    end

    // frame position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_geom) begin
            r_col_cnt   <= '0;
            r_drain_cnt <= '0;
            r_row_cnt   <= '0;
        end else if (i_cmd.accept && !o_status.ignore) begin
            if (i_s_tuser) begin
                if (wrap) begin
                    r_col_cnt   <= '0;
                    r_drain_cnt <= '0;
                    r_row_cnt   <= '0;
                end else begin
                    r_drain_cnt <= x_next[XW-1:0];
                end
            end else if (wrap) begin
                r_col_cnt <= '0;
                r_row_cnt <= r_row_cnt + FH_W'(1);
            end else begin
                r_col_cnt <= x_next[XW-1:0];
            end
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_drain      <= i_s_tuser;
            r_pix        <= i_s_tdata;
            r_x          <= x_now;
            r_want1      <= emit & (x_now != '0);
            r_want2      <= emit & (WW'(x_now) == w_last);
            r_top_is_bot <= i_s_tuser ? (h_eff == FH_W'(1)) : (r_row_cnt <= FH_W'(1));
        end
    end

    // line stores: a holds the previous row, b the one before
    logic [PIX_W-1:0] ram_a_q, ram_b_q;
    logic             store_we;

    assign store_we = i_cmd.load_col & ~r_drain;

    sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_a (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_x),
        .i_wdata (r_pix),
        .i_re    (i_cmd.accept),
        .i_raddr (x_now),
        .o_rdata (ram_a_q)
    );

    sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_b (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_x),
        .i_wdata (ram_a_q),
        .i_re    (i_cmd.accept),
        .i_raddr (x_now),
        .o_rdata (ram_b_q)
    );

    // window: column 2 is the newest
    t_col new_col;

    always_comb begin
        new_col[1] = ram_a_q;
        new_col[2] = r_drain ? ram_a_q : r_pix;
        new_col[0] = r_top_is_bot ? new_col[2] : ram_b_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
        end else if (i_cmd.load_col) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= new_col;
        end
    end

    // gradients; left column reflects at x = 0 and 1
    t_col             lc, mc, rc;
    logic [9:0]       sum_r, sum_l, sum_b, sum_t;
    logic signed [10:0] gx, gy;

    always_comb begin
        if (i_cmd.second) begin
            lc = (r_x == '0) ? r_win[2] : r_win[1];
            mc = r_win[2];
        end else begin
            lc = (r_x == XW'(1)) ? r_win[2] : r_win[0];
            mc = r_win[1];
        end
        rc = r_win[2];
        sum_r = 10'(rc[0]) + {1'b0, rc[1], 1'b0} + 10'(rc[2]);
        sum_l = 10'(lc[0]) + {1'b0, lc[1], 1'b0} + 10'(lc[2]);
        sum_b = 10'(lc[2]) + {1'b0, mc[2], 1'b0} + 10'(rc[2]);
        sum_t = 10'(lc[0]) + {1'b0, mc[0], 1'b0} + 10'(rc[0]);
        gx = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
        gy = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_abs_x <= gx[10] ? 10'(-gx) : gx[9:0];
            r_abs_y <= gy[10] ? 10'(-gy) : gy[9:0];
        end
    end

    // sum of squares, then a restoring square root one bit per step
    logic [19:0] sq_x, sq_y;
    logic [15:0] rad;
    logic [3:0]  pos_hi;
    logic [10:0] rem_sh, trial;

    always_comb begin
        sq_x   = r_abs_x * r_abs_x;
        sq_y   = r_abs_y * r_abs_y;
        rad    = r_sum[15:0];
        pos_hi = {3'd7 - r_step, 1'b1};
        rem_sh = {r_rem, rad[pos_hi -: 2]};
        trial  = {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sum  <= {1'b0, sq_x} + {1'b0, sq_y};
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
        end else if (i_cmd.root_step) begin
            if (rem_sh >= trial) begin
                r_rem  <= 9'(rem_sh - trial);
                r_root <= {r_root[6:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[8:0];
                r_root <= {r_root[6:0], 1'b0};
            end
            r_step <= r_step + 3'd1;
        end
    end

    // result value
    logic             sat;
    logic [PIX_W-1:0] edge_val;

    always_comb begin
        sat = |r_sum[SUM_W-1:16];
        if (r_thr_mode) begin
            edge_val = (THR_SQ_W'(r_sum) > r_thr_sq) ? PIX_MAX : PIX_ZERO;
        end else begin
            edge_val = sat ? PIX_MAX : r_root;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_data <= edge_val;
            r_out_last <= i_cmd.second | ~r_want2;
            r_out_user <= i_cmd.second & r_drain;
        end
    end

    assign o_status.want1     = r_want1;
    assign o_status.want2     = r_want2;
    assign o_status.fast      = r_thr_mode | sat;
    assign o_status.root_last = (r_step == 3'd7);
    assign o_status.out_free  = ~r_out_valid | i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire

// ----- rtl/sobel_edge_magnitude_unit.sv -----
// sobel_edge_magnitude_unit: top level of the 3x3 Sobel gradient magnitude block.
// Depends on sobel_pkg, sobel_ctrl, sobel_dp (which uses sobel_ram).
//
// Channel  Dir  Signals                         Contents (low bit first)
// -------  ---  ------------------------------  --------------------------------
// s        in   i_s_tvalid/o_s_tready           tdata[7:0] pixel_in, tuser cmd
// m        out  o_m_tvalid/i_m_tready           tdata[7:0] edge_value,
//                                               tlast run_last, tuser frame_end
// cfg      in   i_cfg_we/i_cfg_index/i_cfg_wdata  0 width, 1 height, 2 mode, 3 thr
//
// Sequencing: one item at a time. An ignored item is only accepted; any other item
//   that gives no result is accepted, then reads the line stores. Each result adds
//   gradient, square and push steps plus the square root, one bit per step in
//   magnitude mode unless the sum saturates; otherwise the root phase is cut short.
// Reset: synchronous, active low; clears counters and window, loads configuration defaults.
//   Line stores are not cleared; no result of a well-ordered frame reads them early.
// Stalls: a finished result waits in the output register while the next item
//   is taken; any new result holds in its push cycle until that register frees.
`default_nettype none

module sobel_edge_magnitude_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // slave stream: tdata = pixel_in[7:0]; tuser = cmd (1 = drain tick)
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [sobel_pkg::PIX_W-1:0]          i_s_tdata,
    input  wire logic                                 i_s_tuser,
    // master stream: tdata = edge_value[7:0]; tlast = run_last; tuser = frame_end
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic      [sobel_pkg::PIX_W-1:0]          o_m_tdata,
    output logic                                      o_m_tlast,
    output logic                                      o_m_tuser,
    // configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [sobel_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [sobel_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import sobel_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencing: accept, read line stores, then per result gradient,
    // square, root and push
    sobel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // all storage and arithmetic; the output register lives here
    sobel_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/sobel_edge_checker.sv -----
`timescale 1ns / 100ps
// sobel_edge_checker: watches the pixel, result and config ports of the Sobel unit,
// predicts each result in stream order and compares it field by field.
// Depends on sobel_pkg (register indexes, reset values, window column type).

module sobel_edge_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [7:0]                          i_s_tdata,   // pixel_in[7:0]
    input  logic                                i_s_tuser,   // cmd (1 = drain tick)
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [7:0]                          i_m_tdata,   // edge_value[7:0]
    input  logic                                i_m_tlast,   // run_last
    input  logic                                i_m_tuser,   // frame_end
    input  logic                                i_cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output int                                  o_fail_cnt,
    output int                                  o_pending
);

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       frame_end;
    } t_edge_result;

    t_edge_result    edge_expect_q [$];

    // predictor copy of the line stores, window and counters
    logic [7:0]      last_row  [MAX_WIDTH];   // row just above the incoming pixel
    logic [7:0]      older_row [MAX_WIDTH];   // the row above that
    sobel_pkg::t_col win_col [3];             // [0] left, [1] middle, [2] right
    int unsigned     col_cnt;
    int unsigned     row_cnt;
    int unsigned     drain_cnt;
    int              result_idx;

    logic [sobel_pkg::FW_W-1:0]  frame_w;
    logic [sobel_pkg::FH_W-1:0]  frame_h;
    logic                        thr_mode;
    logic [sobel_pkg::THR_W-1:0] thr_level;

    // bitwise integer square root; sums stay below 2^22
    function automatic int unsigned int_sqrt(input int unsigned v);
        int unsigned root;
        root = 0;
        for (int b = 11; b >= 0; b--) begin
            int unsigned trial;
            trial = root | (32'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic logic [7:0] edge_calc(input sobel_pkg::t_col l,
                                             input sobel_pkg::t_col m,
                                             input sobel_pkg::t_col r);
        int gx, gy, sum_sq;
        int unsigned mag;
        gx = (int'(r[0]) + 2 * int'(r[1]) + int'(r[2]))
           - (int'(l[0]) + 2 * int'(l[1]) + int'(l[2]));
        gy = (int'(l[2]) + 2 * int'(m[2]) + int'(r[2]))
           - (int'(l[0]) + 2 * int'(m[0]) + int'(r[0]));
        sum_sq = gx * gx + gy * gy;
        if (thr_mode)
            return (sum_sq > int'(thr_level) * int'(thr_level)) ? 8'hFF : 8'h00;
        mag = int_sqrt(sum_sq);
        return (mag > 255) ? 8'hFF : mag[7:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH result %0d: %s", $time, result_idx, msg);
        o_fail_cnt++;
    endtask

    // one accepted stream transaction -> zero, one or two expected results
    task automatic predict_edges(input logic drain, input logic [7:0] pix);
        int unsigned  w, h, x, r;
        logic [7:0]   top, mid, bot;
        t_edge_result res;
        w = (frame_w == 0) ? 1 : ((frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w);
        h = (frame_h == 0) ? 1 : frame_h;
        // pixel once all rows are in, or drain before the last row is complete: ignored
        if (!drain && row_cnt >= h) return;
        if (drain && row_cnt < h) return;

        x = drain ? drain_cnt : col_cnt;
        if (x >= w) x = w - 1;
        r = drain ? h - 1 : ((row_cnt == 0) ? 0 : row_cnt - 1);

        mid = last_row[x];
        bot = drain ? mid : pix;
        top = (r == 0) ? bot : older_row[x];   // top edge reflects
        win_col[0] = win_col[1];
        win_col[1] = win_col[2];
        win_col[2] = {bot, mid, top};
        if (!drain) begin
            older_row[x] = last_row[x];
            last_row[x]  = pix;
        end

        if (drain || row_cnt >= 1) begin
            if (x >= 1) begin
                // left edge reflects: column -1 reads column 1
                res.value     = edge_calc((x == 1) ? win_col[2] : win_col[0],
                                          win_col[1], win_col[2]);
                res.run_last  = (x != w - 1);
                res.frame_end = 1'b0;
                edge_expect_q.push_back(res);
            end
            if (x == w - 1) begin
                // right edge replicates the last column
                res.value     = edge_calc((x == 0) ? win_col[2] : win_col[1],
                                          win_col[2], win_col[2]);
                res.run_last  = 1'b1;
                res.frame_end = drain;
                edge_expect_q.push_back(res);
            end
        end

        if (drain) begin
            drain_cnt = x + 1;
            if (drain_cnt >= w) begin
                drain_cnt = 0;
                col_cnt   = 0;
                row_cnt   = 0;
            end
        end else begin
            col_cnt = x + 1;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt = (row_cnt + 1) & 32'hFFFF;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_edge_result exp_res;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
                last_row[i]  = '0;
                older_row[i] = '0;
            end
            for (int c = 0; c < 3; c++) win_col[c] = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            drain_cnt  = 0;
            result_idx = 0;
            frame_w    = sobel_pkg::RST_FRAME_WIDTH;
            frame_h    = sobel_pkg::RST_FRAME_HEIGHT;
            thr_mode   = 1'b0;
            thr_level  = sobel_pkg::RST_EDGE_THRESH;
            edge_expect_q.delete();
            o_fail_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sobel_pkg::CFG_FRAME_WIDTH, sobel_pkg::CFG_FRAME_HEIGHT: begin
                        if (i_cfg_index == sobel_pkg::CFG_FRAME_WIDTH)
                            frame_w = i_cfg_wdata[sobel_pkg::FW_W-1:0];
                        else
                            frame_h = i_cfg_wdata[sobel_pkg::FH_W-1:0];
                        // geometry change restarts the frame, stores keep their data
                        col_cnt   = 0;
                        row_cnt   = 0;
                        drain_cnt = 0;
                    end
                    sobel_pkg::CFG_THRESH_MODE: thr_mode  = i_cfg_wdata[0];
                    sobel_pkg::CFG_EDGE_THRESH: thr_level = i_cfg_wdata[sobel_pkg::THR_W-1:0];
                    default: ;
                endcase
            end

            // results out first: nothing accepted on this edge can be out already
            if (i_m_tvalid && i_m_tready) begin
                if (edge_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, edge_value %0d", i_m_tdata));
                end else begin
                    exp_res = edge_expect_q.pop_front();
                    if (i_m_tdata !== exp_res.value)
                        report_mismatch($sformatf("edge_value %0d, expected %0d",
                                                  i_m_tdata, exp_res.value));
                    if (i_m_tlast !== exp_res.run_last)
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  i_m_tlast, exp_res.run_last));
                    if (i_m_tuser !== exp_res.frame_end)
                        report_mismatch($sformatf("frame_end %b, expected %b",
                                                  i_m_tuser, exp_res.frame_end));
                end
                result_idx++;
            end

            if (i_s_tvalid && i_s_tready) predict_edges(i_s_tuser, i_s_tdata);
        end
        o_pending = edge_expect_q.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench: stimulus and verdict for sobel_edge_magnitude_unit.
// Depends on sobel_pkg, the unit's RTL and tb/sobel_edge_checker.sv.

module testbench;

    localparam int   MAX_W         = 1024;
    localparam int   SETTLE_CYCLES = 40;        // wait after the last result for ignored items
    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam int   RANDOM_ITEMS  = 470;

    // stream item kinds (tuser)
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum int { STYLE_UNIFORM, STYLE_BINARY, STYLE_SMOOTH } t_pix_style;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // pixel_in[7:0]
    logic        s_tuser   = 1'b0;  // cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;           // edge_value[7:0]
    logic        m_tlast;           // run_last
    logic        m_tuser;           // frame_end
    logic        cfg_we    = 1'b0;
    logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sobel_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int src_idle    = 0;    // percent of cycles the sender holds back
    int sink_stall  = 0;    // percent of cycles the receiver deasserts tready
    int frame_items = 0;    // well-formed items of the random part
    int cycle_cnt   = 0;
    int fail_cnt;
    int pending_cnt;

    sobel_edge_magnitude_unit #(
        .MAX_WIDTH (MAX_W)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    sobel_edge_checker #(
        .MAX_WIDTH (MAX_W)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .i_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending_cnt)
    );

    // 10 ns clock
    always begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // receiver: one fresh tready decision per edge
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall);
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // register write: one edge with we high, one to drop it
    task automatic write_reg(input logic [sobel_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[sobel_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one stream transaction; tready sampled at the falling edge, stable up to the next rise
    task automatic send_item(input logic cmd, input logic [7:0] pix);
        logic rdy;
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= cmd;
        do begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end while (!rdy);
    endtask

    // drop valid, wait for every expected result, then let in-flight ignored items finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_cnt != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_pixel(input t_pix_style style);
        case (style)
            STYLE_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;  // saturates
            STYLE_SMOOTH: return 8'(96 + $urandom_range(0, 12));        // small gradients
            default:      return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // raster frame plus drain row; noisy adds ignored early drains and a late pixel,
    // cut stops partway through (the next geometry write restarts the frame)
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input t_pix_style style, input bit noisy, input bit cut);
        int unsigned cut_at;
        cut_at = cut ? $urandom_range(0, w * h - 1) : w * h;
        for (int unsigned k = 0; k < w * h; k++) begin
            if (k == cut_at) return;
            if (noisy && $urandom_range(0, 19) == 0) send_item(CMD_DRAIN, 8'($urandom));
            send_item(CMD_PIXEL, pick_pixel(style));
            frame_items++;
        end
        if (noisy && $urandom_range(0, 3) == 0) send_item(CMD_PIXEL, 8'($urandom));
        for (int unsigned d = 0; d < w; d++) begin
            send_item(CMD_DRAIN, 8'($urandom));
            frame_items++;
        end
    endtask

    initial begin
        int unsigned w, h, thr;
        bit          mode, cut_frame;
        int          n_frames;
        int          phase;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: reset geometry, then 3x2 frames with the edge cases ----
        src_idle   = 0;
        sink_stall = 0;
        // row 0 of the reset 1024-wide frame: nothing comes out
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_PIXEL, 8'h5A);
        wait_idle();
        write_reg(sobel_pkg::CFG_FRAME_WIDTH, 3);     // also restarts the frame
        write_reg(sobel_pkg::CFG_FRAME_HEIGHT, 2);
        send_item(CMD_DRAIN, 8'h00);                  // drain before the rows: ignored
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_PIXEL, 8'hFF);                  // pixel past the last row: ignored
        send_item(CMD_DRAIN, 8'hFF);
        send_item(CMD_DRAIN, 8'h00);
        send_item(CMD_DRAIN, 8'hFF);
        wait_idle();
        // binary mode against the reset threshold
        write_reg(sobel_pkg::CFG_THRESH_MODE, 1);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_item(CMD_DRAIN, 8'h00);
        send_item(CMD_DRAIN, 8'h00);
        send_item(CMD_DRAIN, 8'h00);
        wait_idle();

        // ---- extreme settings ----
        src_idle   = 11;
        sink_stall = 11;
        // width 0 and height 0 act as a 1x1 frame
        write_reg(sobel_pkg::CFG_FRAME_WIDTH, 0);
        write_reg(sobel_pkg::CFG_FRAME_HEIGHT, 0);
        write_reg(sobel_pkg::CFG_THRESH_MODE, 0);
        write_reg(sobel_pkg::CFG_EDGE_THRESH, 2047);
        repeat (3) send_frame(1, 1, STYLE_UNIFORM, 1'b1, 1'b0);
        wait_idle();
        // tallest frame: one column, only a slice of it, then restarted
        write_reg(sobel_pkg::CFG_FRAME_WIDTH, 1);
        write_reg(sobel_pkg::CFG_FRAME_HEIGHT, 65535);
        repeat (40) send_item(CMD_PIXEL, pick_pixel(STYLE_UNIFORM));
        wait_idle();
        // width above the maximum clamps to a full row: a stretch of row 0 gives nothing
        write_reg(sobel_pkg::CFG_FRAME_WIDTH, 2047);
        write_reg(sobel_pkg::CFG_FRAME_HEIGHT, 1);
        repeat (24) send_item(CMD_PIXEL, pick_pixel(STYLE_UNIFORM));
        send_item(CMD_DRAIN, 8'h00);                  // row not complete: ignored
        wait_idle();
        // threshold extremes in binary mode
        write_reg(sobel_pkg::CFG_FRAME_WIDTH, 5);
        write_reg(sobel_pkg::CFG_FRAME_HEIGHT, 3);
        write_reg(sobel_pkg::CFG_THRESH_MODE, 1);
        write_reg(sobel_pkg::CFG_EDGE_THRESH, 0);
        send_frame(5, 3, STYLE_SMOOTH, 1'b0, 1'b0);
        wait_idle();
        write_reg(sobel_pkg::CFG_EDGE_THRESH, 2047);
        send_frame(5, 3, STYLE_BINARY, 1'b0, 1'b0);
        wait_idle();

        // ---- random phases: mostly well-formed frames, some noise and cut frames ----
        frame_items = 0;
        phase       = 0;
        while (frame_items < RANDOM_ITEMS) begin
            case (phase % 4)
                0:       begin src_idle = 0;  sink_stall = 0;  end
                1:       begin src_idle = 45; sink_stall = 0;  end
                2:       begin src_idle = 0;  sink_stall = 45; end
                default: begin src_idle = 11; sink_stall = 11; end
            endcase
            w    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h    = $urandom_range(1, 6);
            mode = $urandom_range(0, 1);
            thr  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 300);
            write_reg(sobel_pkg::CFG_FRAME_WIDTH, w);
            write_reg(sobel_pkg::CFG_FRAME_HEIGHT, h);
            write_reg(sobel_pkg::CFG_THRESH_MODE, mode);
            write_reg(sobel_pkg::CFG_EDGE_THRESH, thr);
            n_frames = $urandom_range(1, 3);
            for (int f = 0; f < n_frames; f++) begin
                cut_frame = ($urandom_range(0, 11) == 0);
                send_frame(w, h, t_pix_style'($urandom_range(0, 2)),
                           $urandom_range(0, 2) == 0, cut_frame);
                if (cut_frame) break;
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sobel_edge_magnitude_unit.f -----
rtl/sobel_pkg.sv
rtl/sobel_ram.sv
rtl/sobel_ctrl.sv
rtl/sobel_dp.sv
rtl/sobel_edge_magnitude_unit.sv
tb/sobel_edge_checker.sv
tb/testbench.sv
